[src/dac_pkg.sv]
package dac_pkg;

    localparam int MAX_LENGTH  = 9;
    localparam int DIGIT_LIMIT = 6;

    localparam int CHAR_W     = 8;
    localparam int STATUS_W   = 4;
    localparam int LENGTH_W   = 4;
    localparam int MANT_W     = 21;
    localparam int FRAC_W     = 3;
    localparam int INDEX_W    = 4;
    localparam int SIGN_CNT_W = 2;
    localparam int DIGIT_CNT_W = $clog2(DIGIT_LIMIT + 2);

    localparam logic [CHAR_W-1:0] END_MARK_RESET = 8'd13;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK        = 4'd0;
    localparam t_status ST_LENGTH    = 4'd1;
    localparam t_status ST_CHAR      = 4'd2;
    localparam t_status ST_DIGITS    = 4'd3;
    localparam t_status ST_POINT_POS = 4'd4;
    localparam t_status ST_POINTS    = 4'd5;
    localparam t_status ST_MINUS_POS = 4'd6;
    localparam t_status ST_MINUSES   = 4'd7;
    localparam t_status ST_PLUS_POS  = 4'd8;
    localparam t_status ST_PLUSES    = 4'd9;
    localparam t_status ST_SPACE_POS = 4'd10;
    localparam t_status ST_SPACES    = 4'd11;
    localparam t_status ST_NO_DIGIT  = 4'd12;

endpackage

[src/decimal_argument_checker.sv]
// Checks a signed decimal argument one character word at a time: an optional
// leading space, at most one sign, up to DIGIT_LIMIT digits with at most one
// point after the first digit, then the end mark (i_cfg_data, carriage return
// after reset). One result word per argument, on the end mark, on the first
// broken rule, or with bad-length status after MAX_LENGTH characters with no
// end mark; a good result carries the value as a signed mantissa and a count
// of fraction digits, error results carry zeros there. After a result the
// block drops characters until one arrives with i_start_req set, which is
// also the state after reset. Each word passes an input register and the
// parse update into the result register, so one word is taken every cycle
// unless a stalled result word holds the input; the result word is loaded
// by the parse update of the character word that causes it.
module decimal_argument_checker
    import dac_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CHAR_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CHAR_W-1:0]        i_character,
    input  logic                     i_start_req,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [LENGTH_W-1:0]      o_length,
    output logic signed [MANT_W-1:0] o_mantissa,
    output logic [FRAC_W-1:0]        o_fraction_digits
);

    logic [CHAR_W-1:0]      r_end_mark;

    logic                   r_in_valid;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_in_start;

    logic [INDEX_W-1:0]     r_char_index, n_char_index, c_char_index;
    logic [SIGN_CNT_W-1:0]  r_space_cnt, n_space_cnt, c_space_cnt;
    logic [SIGN_CNT_W-1:0]  r_plus_cnt, n_plus_cnt, c_plus_cnt;
    logic [SIGN_CNT_W-1:0]  r_minus_cnt, n_minus_cnt, c_minus_cnt;
    logic [SIGN_CNT_W-1:0]  r_point_cnt, n_point_cnt, c_point_cnt;
    logic [DIGIT_CNT_W-1:0] r_digit_cnt, n_digit_cnt, c_digit_cnt;
    logic [MANT_W-1:0]      r_magnitude, n_magnitude, c_magnitude;
    logic [FRAC_W-1:0]      r_frac_cnt, n_frac_cnt, c_frac_cnt;
    logic                   r_finished, n_finished, c_finished;

    logic                   r_out_valid;
    t_status                r_status;
    logic [LENGTH_W-1:0]    r_length;
    logic [MANT_W-1:0]      r_mantissa;
    logic [FRAC_W-1:0]      r_frac;

    logic                   move;
    logic                   emit;
    t_status                status;
    logic [MANT_W-1:0]      signed_mag;
    logic [CHAR_W-1:0]      digit_val;

    // parse stage advances when the result register is free or being taken
    assign move       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;

    always_comb begin
        c_char_index = r_in_start ? '0 : r_char_index;
        c_space_cnt  = r_in_start ? '0 : r_space_cnt;
        c_plus_cnt   = r_in_start ? '0 : r_plus_cnt;
        c_minus_cnt  = r_in_start ? '0 : r_minus_cnt;
        c_point_cnt  = r_in_start ? '0 : r_point_cnt;
        c_digit_cnt  = r_in_start ? '0 : r_digit_cnt;
        c_magnitude  = r_in_start ? '0 : r_magnitude;
        c_frac_cnt   = r_in_start ? '0 : r_frac_cnt;
        c_finished   = r_in_start ? 1'b0 : r_finished;

        n_char_index = c_char_index;
        n_space_cnt  = c_space_cnt;
        n_plus_cnt   = c_plus_cnt;
        n_minus_cnt  = c_minus_cnt;
        n_point_cnt  = c_point_cnt;
        n_digit_cnt  = c_digit_cnt;
        n_magnitude  = c_magnitude;
        n_frac_cnt   = c_frac_cnt;
        emit         = 1'b0;
        status       = ST_OK;
        digit_val    = r_char - CH_ZERO;

        if (!c_finished) begin
            priority if (r_char == r_end_mark) begin
                emit   = 1'b1;
                status = (c_digit_cnt == '0) ? ST_NO_DIGIT : ST_OK;
            end else if (r_char == CH_SPACE) begin
                n_space_cnt = c_space_cnt + 1'b1;
                if (c_space_cnt != '0) begin
                    emit = 1'b1; status = ST_SPACES;
                end else if (c_plus_cnt != '0 || c_minus_cnt != '0 ||
                             c_digit_cnt != '0) begin
                    emit = 1'b1; status = ST_SPACE_POS;
                end
            end else if (r_char == CH_PLUS) begin
                n_plus_cnt = c_plus_cnt + 1'b1;
                if (c_plus_cnt != '0) begin
                    emit = 1'b1; status = ST_PLUSES;
                end else if (c_minus_cnt != '0 || c_digit_cnt != '0) begin
                    emit = 1'b1; status = ST_PLUS_POS;
                end
            end else if (r_char == CH_MINUS) begin
                n_minus_cnt = c_minus_cnt + 1'b1;
                if (c_minus_cnt != '0) begin
                    emit = 1'b1; status = ST_MINUSES;
                end else if (c_plus_cnt != '0 || c_digit_cnt != '0) begin
                    emit = 1'b1; status = ST_MINUS_POS;
                end
            end else if (r_char == CH_POINT) begin
                n_point_cnt = c_point_cnt + 1'b1;
                if (c_point_cnt != '0) begin
                    emit = 1'b1; status = ST_POINTS;
                end else if (c_digit_cnt == '0) begin
                    emit = 1'b1; status = ST_POINT_POS;
                end
            end else if (r_char >= CH_ZERO && r_char <= CH_NINE) begin
                n_digit_cnt = c_digit_cnt + 1'b1;
                if (c_digit_cnt >= DIGIT_CNT_W'(DIGIT_LIMIT)) begin
                    emit = 1'b1; status = ST_DIGITS;
                end else begin
                    // times ten as two shifts, wraps at the mantissa width
                    n_magnitude = (c_magnitude << 3) + (c_magnitude << 1)
                                + MANT_W'(digit_val[3:0]);
                    if (c_point_cnt != '0)
                        n_frac_cnt = c_frac_cnt + 1'b1;
                end
            end else begin
                emit = 1'b1; status = ST_CHAR;
            end

            if (!emit) begin
                n_char_index = c_char_index + 1'b1;
                if (n_char_index >= INDEX_W'(MAX_LENGTH)) begin
                    emit = 1'b1; status = ST_LENGTH;
                end
            end
        end

        n_finished = c_finished || emit;
        signed_mag = (c_minus_cnt != '0) ? (~c_magnitude + 1'b1) : c_magnitude;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_mark   <= END_MARK_RESET;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_char_index <= '0;
            r_space_cnt  <= '0;
            r_plus_cnt   <= '0;
            r_minus_cnt  <= '0;
            r_point_cnt  <= '0;
            r_digit_cnt  <= '0;
            r_magnitude  <= '0;
            r_frac_cnt   <= '0;
            r_finished   <= 1'b1;
        end else begin
            if (i_cfg_we)
                r_end_mark <= i_cfg_data;
            if (!o_in_stall)
                r_in_valid <= i_in_valid;
            if (move) begin
                r_char_index <= n_char_index;
                r_space_cnt  <= n_space_cnt;
                r_plus_cnt   <= n_plus_cnt;
                r_minus_cnt  <= n_minus_cnt;
                r_point_cnt  <= n_point_cnt;
                r_digit_cnt  <= n_digit_cnt;
                r_magnitude  <= n_magnitude;
                r_frac_cnt   <= n_frac_cnt;
                r_finished   <= n_finished;
                r_out_valid  <= emit;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_char     <= i_character;
            r_in_start <= i_start_req;
        end
        if (move && emit) begin
            r_status <= status;
            if (status == ST_OK) begin
                r_length   <= LENGTH_W'(c_char_index);
                r_mantissa <= signed_mag;
                r_frac     <= c_frac_cnt;
            end else begin
                r_length   <= '0;
                r_mantissa <= '0;
                r_frac     <= '0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_length          = r_length;
    assign o_mantissa        = r_mantissa;
    assign o_fraction_digits = r_frac;

    a_quiet_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && !r_in_start && r_finished |=> !o_out_valid)
        else $error("result word from a finished parse");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            o_length == '0 && o_mantissa == '0 && o_fraction_digits == '0)
        else $error("error result carries nonzero fields");

    a_ok_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |-> o_length != '0)
        else $error("good result with zero length");

    a_index_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_finished |-> r_char_index < INDEX_W'(MAX_LENGTH))
        else $error("character index past length limit while parsing");

endmodule

[tb/decimal_argument_checker_tb.sv]
module decimal_argument_checker_tb;
    import dac_pkg::*;

    localparam int LONG_HOLD = 80;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              start;
    } t_char_word;

    typedef struct {
        t_status                  status;
        logic [LENGTH_W-1:0]      len;
        logic signed [MANT_W-1:0] mant;
        logic [FRAC_W-1:0]        frac;
    } t_arg_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CHAR_W-1:0]        i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CHAR_W-1:0]        i_character = '0;
    logic                     i_start_req = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [STATUS_W-1:0]      o_status;
    logic [LENGTH_W-1:0]      o_length;
    logic signed [MANT_W-1:0] o_mantissa;
    logic [FRAC_W-1:0]        o_fraction_digits;

    t_char_word  chars_to_send[$];
    t_arg_result expected_results[$];

    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    // parser shadow state
    logic [CHAR_W-1:0] cfg_end_mark = END_MARK_RESET;
    int p_index, p_spaces, p_pluses, p_minuses, p_points, p_digits, p_frac;
    int p_magnitude;
    bit p_done = 1'b1;

    decimal_argument_checker DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_character       (i_character),
        .i_start_req       (i_start_req),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_length          (o_length),
        .o_mantissa        (o_mantissa),
        .o_fraction_digits (o_fraction_digits)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input int want, input int got);
        $display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    task automatic close_argument(input t_status st);
        t_arg_result r;
        r.status = st;
        r.len    = '0;
        r.mant   = '0;
        r.frac   = '0;
        if (st == ST_OK) begin
            r.len  = LENGTH_W'(p_index);
            r.mant = MANT_W'((p_minuses != 0) ? -p_magnitude : p_magnitude);
            r.frac = FRAC_W'(p_frac);
        end
        expected_results.push_back(r);
        p_done = 1'b1;
    endtask

    // Advance the shadow parser by one accepted character word.
    task automatic parse_char(input logic [CHAR_W-1:0] ch, input logic start);
        t_status st;
        bit      hit;
        hit = 1'b0;
        st  = ST_OK;
        if (start) begin
            p_index = 0; p_spaces = 0; p_pluses = 0; p_minuses = 0;
            p_points = 0; p_digits = 0; p_magnitude = 0; p_frac = 0;
            p_done = 1'b0;
        end
        if (p_done)
            return;
        // end mark wins over every other class
        if (ch == cfg_end_mark) begin
            hit = 1'b1;
            st  = (p_digits == 0) ? ST_NO_DIGIT : ST_OK;
        end else if (ch == CH_SPACE) begin
            p_spaces++;
            hit = 1'b1;
            if (p_spaces > 1)
                st = ST_SPACES;
            else if (p_pluses != 0 || p_minuses != 0 || p_digits != 0)
                st = ST_SPACE_POS;
            else
                hit = 1'b0;
        end else if (ch == CH_PLUS) begin
            p_pluses++;
            hit = 1'b1;
            if (p_pluses > 1)
                st = ST_PLUSES;
            else if (p_minuses != 0 || p_digits != 0)
                st = ST_PLUS_POS;
            else
                hit = 1'b0;
        end else if (ch == CH_MINUS) begin
            p_minuses++;
            hit = 1'b1;
            if (p_minuses > 1)
                st = ST_MINUSES;
            else if (p_pluses != 0 || p_digits != 0)
                st = ST_MINUS_POS;
            else
                hit = 1'b0;
        end else if (ch == CH_POINT) begin
            p_points++;
            hit = 1'b1;
            if (p_points > 1)
                st = ST_POINTS;
            else if (p_digits == 0)
                st = ST_POINT_POS;
            else
                hit = 1'b0;
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            p_digits++;
            if (p_digits > DIGIT_LIMIT) begin
                hit = 1'b1;
                st  = ST_DIGITS;
            end else begin
                p_magnitude = p_magnitude * 10 + int'(ch) - int'(CH_ZERO);
                if (p_points != 0)
                    p_frac++;
            end
        end else begin
            hit = 1'b1;
            st  = ST_CHAR;
        end
        if (!hit) begin
            p_index++;
            if (p_index >= MAX_LENGTH) begin
                hit = 1'b1;
                st  = ST_LENGTH;
            end
        end
        if (hit)
            close_argument(st);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        unique case ($urandom_range(0, 7))
            0: return CH_SPACE;
            1: return CH_PLUS;
            2: return CH_MINUS;
            3: return CH_POINT;
            4, 5: return CH_ZERO + CHAR_W'($urandom_range(0, 9));
            6: return cfg_end_mark;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_char(input logic [CHAR_W-1:0] ch, input logic start);
        t_char_word w;
        w.ch    = ch;
        w.start = start;
        chars_to_send.push_back(w);
    endtask

    task automatic queue_text(input string s, input bit terminate);
        for (int k = 0; k < s.len(); k++)
            queue_char(s[k], k == 0);
        if (terminate)
            queue_char(cfg_end_mark, s.len() == 0);
    endtask

    // Mostly well-formed arguments; some with one flaw, the rest noise.
    task automatic queue_random_arg();
        logic [CHAR_W-1:0] txt[$];
        int kind, ndig, pt, flaw, restart_at;
        bit lead_start, terminate;
        kind       = $urandom_range(0, 99);
        lead_start = 1'b1;
        terminate  = 1'b1;
        restart_at = -1;
        if (kind < 80) begin
            if ($urandom_range(0, 3) == 0)
                txt.push_back(CH_SPACE);
            case ($urandom_range(0, 2))
                0: txt.push_back(CH_MINUS);
                1: txt.push_back(CH_PLUS);
                default: ;
            endcase
            ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(0, DIGIT_LIMIT + 2)
                                                : $urandom_range(1, DIGIT_LIMIT);
            pt = (ndig != 0 && $urandom_range(0, 1) == 1) ? $urandom_range(1, ndig) : 0;
            for (int k = 0; k < ndig; k++) begin
                txt.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
                if (k + 1 == pt)
                    txt.push_back(CH_POINT);
            end
            if (kind >= 60) begin
                flaw = $urandom_range(0, 3);
                if (flaw == 0) begin
                    terminate = 1'b0;
                end else if (flaw == 1) begin
                    restart_at = $urandom_range(1, txt.size() + 1);
                end else if (txt.size() == 0) begin
                    txt.push_back(pick_char());
                end else begin
                    txt.insert($urandom_range(0, txt.size() - 1), pick_char());
                end
            end
        end else begin
            lead_start = ($urandom_range(0, 3) != 0);
            terminate  = 1'b0;
            ndig       = $urandom_range(1, 10);
            repeat (ndig) txt.push_back(pick_char());
        end
        if (terminate)
            txt.push_back(cfg_end_mark);
        foreach (txt[k])
            queue_char(txt[k], (k == 0 && lead_start) || k == restart_at);
    endtask

    task automatic queue_random_args(input int n_words);
        int goal;
        goal = chars_to_send.size() + n_words;
        while (chars_to_send.size() < goal)
            queue_random_arg();
    endtask

    task automatic write_end_mark(input logic [CHAR_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_end_mark = v;
    endtask

    // Wait for the input side to empty, then for outstanding results.
    task automatic settle();
        int spins;
        do @(negedge i_clk);
        while (chars_to_send.size() != 0 || i_in_valid);
        spins = 0;
        while (expected_results.size() != 0 && spins < 4000) begin
            @(negedge i_clk);
            spins++;
        end
        if (expected_results.size() != 0) begin
            flag_mismatch("results never arrived, count", 0, expected_results.size());
            expected_results.delete();
        end
        // a trailing word may produce no result; let the pipe empty
        repeat (6) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_words
        t_char_word w;
        bit fire;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && !o_in_stall;
            if (fire)
                parse_char(i_character, i_start_req);
            if (i_in_valid && !fire) begin
                // hold the stalled word
            end else if (chars_to_send.size() != 0 &&
                         $urandom_range(1, 100) > send_idle_pct) begin
                w = chars_to_send.pop_front();
                i_in_valid  <= 1'b1;
                i_character <= w.ch;
                i_start_req <= w.start;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : drive_stall
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (holds_asked != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            i_out_stall  <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(1, 100) <= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_arg_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                flag_mismatch("result word with none pending, status", -1, int'(o_status));
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    flag_mismatch("status", int'(want.status), int'(o_status));
                if (o_length !== want.len)
                    flag_mismatch("length", int'(want.len), int'(o_length));
                if (o_mantissa !== want.mant)
                    flag_mismatch("mantissa", int'(want.mant), int'(o_mantissa));
                if (o_fraction_digits !== want.frac)
                    flag_mismatch("fraction digits", int'(want.frac),
                                  int'(o_fraction_digits));
            end
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 78;
        write_end_mark(END_MARK_RESET);
        queue_text("-9.99999", 1);      // widest mantissa, most fraction digits
        queue_text("-0.", 1);           // negative zero, point right before end mark
        queue_char(8'hFF, 1'b0);        // dropped: no start after a result
        queue_text(".", 0);
        queue_text("++", 0);
        queue_text("+-", 0);
        queue_text("-+", 0);
        queue_text("--", 0);
        queue_text("  ", 0);
        queue_text("1 ", 0);
        queue_text("1..", 0);
        queue_char(8'hFF, 1'b1);
        queue_char(8'h00, 1'b1);
        queue_text("", 1);              // end mark alone
        queue_random_args(420);
        settle();

        write_end_mark(8'hFF);
        queue_random_args(450);
        settle();

        send_idle_pct = 78;
        recv_idle_pct = 19;
        write_end_mark(8'h00);
        queue_random_args(450);
        settle();

        // no idling; a long output hold backs the block up into its input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_end_mark(CH_POINT);
        queue_random_args(320);
        repeat (150) @(posedge i_clk);
        holds_asked++;
        settle();

        write_end_mark(CH_ZERO + 8'd7);
        queue_random_args(320);
        repeat (100) @(posedge i_clk);
        holds_asked++;
        settle();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #(8 * 600000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
src/dac_pkg.sv
src/decimal_argument_checker.sv
tb/decimal_argument_checker_tb.sv
